### rtl/chss_pkg.sv
// Shared types and constants for the cubic Hermite segment sampler.
// Used by the controller, the datapath and the top level.
package chss_pkg;

   localparam int MAX_SAMPLES_DEF = 64;
   localparam int COORD_W         = 32;
   localparam int COEF_W          = 40;
   localparam int T_W             = 17;          // 0 .. 65536
   localparam int PROD_W          = COEF_W + T_W + 1;
   localparam int IDX_W           = 6;
   localparam int SPP_W           = 7;
   localparam int TSTEP_W         = 16;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 16;
   localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

   // Indexes past the last register are ignored on write.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPP   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_TSTEP = CSR_ADDR_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       capture;    // take a control point, form coefficients
      logic       load_acc;   // accumulator <- cubic coefficient
      logic       t_clr;      // parameter back to zero
      logic       t_adv;      // parameter += t_step, clamped at one
      logic       mul;        // product <- accumulator * t
      logic       add;        // accumulator <- rounded product + coefficient
      logic [1:0] step;       // Horner step 0..2
   } cmd_type;

endpackage

### rtl/chss_ctrl.sv
// Sequencer of the sampler: accepts control points, counts samples and
// Horner steps, and drives the datapath commands. Uses chss_pkg.
module chss_ctrl
   import chss_pkg::*;
#(
   parameter int MaxSamples = MAX_SAMPLES_DEF,
   localparam int KW = $clog2(MaxSamples + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             first_point,
   input  logic [SPP_W-1:0] spp,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [IDX_W-1:0] sample_index,
   output logic             last_of_segment,
   output cmd_type          cmd
);

   state_type     state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] n_ff, n_in;
   logic [1:0]    step_ff, step_in;
   logic          have_prev_ff, have_prev_in;
   logic          req_acc, rsp_acc, last, start;
   logic [KW-1:0] n_cap;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign n_cap   = (32'(spp) > MaxSamples) ? KW'(MaxSamples) : KW'(spp);
   assign start   = !first_point && have_prev_ff && (n_cap != '0);
   assign last    = ((KW+1)'(k_ff) + (KW+1)'(1)) == (KW+1)'(n_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_acc && start) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = (step_ff == 2'd2) ? ST_OUT : ST_MUL;
         ST_OUT: begin
            if (rsp_acc) state_in = last ? ST_IDLE : ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and counters.
   always_comb begin
      cmd          = '0;
      cmd.step     = step_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      k_in         = k_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      have_prev_in = have_prev_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               cmd.capture  = 1'b1;
               cmd.load_acc = 1'b1;
               cmd.t_clr    = 1'b1;
               have_prev_in = 1'b1;
               n_in         = n_cap;
               k_in         = '0;
               step_in      = 2'd0;
            end
         end
         ST_MUL: cmd.mul = 1'b1;
         ST_ADD: begin
            cmd.add = 1'b1;
            step_in = (step_ff == 2'd2) ? 2'd0 : step_ff + 2'd1;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_acc && !last) begin
               cmd.load_acc = 1'b1;
               cmd.t_adv    = 1'b1;
               k_in         = k_ff + KW'(1);
            end
         end
         default: ;
      endcase
   end

   assign sample_index    = IDX_W'(k_ff);
   assign last_of_segment = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         n_ff         <= '0;
         step_ff      <= 2'd0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         have_prev_ff <= have_prev_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input taken while a sample is pending");
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (k_ff < n_ff)) else $error("sample index past segment length");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff != 2'd3) else $error("Horner step out of range");
   a_out_after_steps: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.add) && $past(step_ff) == 2'd2)
      else $error("sample shown before all Horner steps");
`endif

endmodule

### rtl/chss_dp.sv
// Datapath of the sampler: previous point, cubic coefficients, parameter
// register and one Horner multiplier per axis. Uses chss_pkg.
module chss_dp
   import chss_pkg::*;
(
   input  logic                      clock,
   input  cmd_type                   cmd,
   input  logic [TSTEP_W-1:0]        t_step,
   input  logic signed [COORD_W-1:0] pos [3],
   input  logic signed [COORD_W-1:0] tan [3],
   output logic signed [COORD_W-1:0] res [3]
);

   logic signed [COORD_W-1:0] ppos_ff [3];
   logic signed [COORD_W-1:0] ptan_ff [3];
   logic signed [COEF_W-1:0]  coef_ff [3][4];
   logic signed [COEF_W-1:0]  acc_ff  [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic [T_W-1:0]            t_ff, t_in;
   logic [T_W:0]              t_sum;

   assign t_sum = {1'b0, t_ff} + (T_W+1)'(t_step);
   assign t_in  = cmd.t_clr ? '0 :
                  (t_sum > (T_W+1)'(ONE_Q16)) ? ONE_Q16 : t_sum[T_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.t_clr || cmd.t_adv) t_ff <= t_in;
   end

   for (genvar ax = 0; ax < 3; ax++) begin : g_axis
      logic signed [COEF_W-1:0] p0, p1, m0, m1, sel_coef;
      logic signed [PROD_W-1:0] biased;
      logic signed [COEF_W-1:0] rnd;

      assign p0 = COEF_W'(ppos_ff[ax]);
      assign m0 = COEF_W'(ptan_ff[ax]);
      assign p1 = COEF_W'(pos[ax]);
      assign m1 = COEF_W'(tan[ax]);

      // Horner steps add b, c, then d.
      assign sel_coef = coef_ff[ax][2'(cmd.step + 2'd1)];
      assign biased   = prod_ff[ax] + PROD_W'(32768);
      assign rnd      = biased[COEF_W+15:16];

      always_ff @(posedge clock) begin
         if (cmd.capture) begin
            ppos_ff[ax]    <= pos[ax];
            ptan_ff[ax]    <= tan[ax];
            coef_ff[ax][0] <= (p0 <<< 1) - (p1 <<< 1) + m0 + m1;
            coef_ff[ax][1] <= (p1 - p0) * 3 - (m0 <<< 1) - m1;
            coef_ff[ax][2] <= m0;
            coef_ff[ax][3] <= p0;
         end
         if (cmd.mul)
            prod_ff[ax] <= PROD_W'(acc_ff[ax]) * $signed({1'b0, t_ff});
         if (cmd.load_acc)
            acc_ff[ax] <= cmd.capture ? (p0 <<< 1) - (p1 <<< 1) + m0 + m1
                                      : coef_ff[ax][0];
         else if (cmd.add)
            acc_ff[ax] <= rnd + sel_coef;
      end

      // Clamp to the Q16.16 range.
      always_comb begin
         if (acc_ff[ax] > COEF_W'(32'sh7FFF_FFFF))
            res[ax] = 32'sh7FFF_FFFF;
         else if (acc_ff[ax] < -COEF_W'(33'sh0_8000_0000))
            res[ax] = 32'sh8000_0000;
         else
            res[ax] = acc_ff[ax][COORD_W-1:0];
      end
   end

endmodule

### rtl/cubic_hermite_segment_sampler_unit.sv
// Top level of the cubic Hermite segment sampler: configuration registers,
// sequencer and datapath. Uses chss_pkg, chss_ctrl and chss_dp.
//
//  channel | ports      | payload
//  --------+------------+--------------------------------------------------
//  input   | req_t*     | tdata: pos_x,pos_y,pos_z,tan_x,tan_y,tan_z; tuser: first_point
//  result  | rsp_t*     | tdata: out_x,out_y,out_z; tuser: sample_index; tlast: last
//  config  | csr_*      | index 0 samples_per_segment, index 1 t_step
//
// Each sample runs three multiply and add pairs of the Horner loop on one
// multiplier per axis, then shows the result until the receiver takes it.
// A new control point is taken only while no sample of a segment is pending.
// Reset is synchronous, clears the sequencer and the previous-point flag, and sets the config registers to defaults.
module cubic_hermite_segment_sampler_unit
   import chss_pkg::*;
#(
   parameter int MaxSamples = MAX_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [191:0]          req_tdata,  // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z
   input  logic                  req_tuser,  // first_point
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,  // out_x, out_y, out_z
   output logic [IDX_W-1:0]      rsp_tuser,  // sample_index
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SPP_W-1:0]          spp_ff;
   logic [TSTEP_W-1:0]        tstep_ff;
   cmd_type                   cmd;
   logic signed [COORD_W-1:0] pos [3];
   logic signed [COORD_W-1:0] tan [3];
   logic signed [COORD_W-1:0] res [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff   <= SPP_W'(16);
         tstep_ff <= TSTEP_W'(4096);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SPP:   spp_ff   <= csr_wdata[SPP_W-1:0];
            CSR_TSTEP: tstep_ff <= csr_wdata[TSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar ax = 0; ax < 3; ax++) begin : g_unpack
      assign pos[ax] = req_tdata[ax*COORD_W +: COORD_W];
      assign tan[ax] = req_tdata[(ax+3)*COORD_W +: COORD_W];
   end

   assign rsp_tdata = {res[2], res[1], res[0]};

   chss_ctrl #(.MaxSamples(MaxSamples)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .first_point     (req_tuser),
      .spp             (spp_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .sample_index    (rsp_tuser),
      .last_of_segment (rsp_tlast),
      .cmd             (cmd)
   );

   chss_dp u_dp (
      .clock  (clock),
      .cmd    (cmd),
      .t_step (tstep_ff),
      .pos    (pos),
      .tan    (tan),
      .res    (res)
   );

endmodule
